// File: src/clt_pkg.sv
// Shared types, widths and character codes for the command line tokenizer.
`timescale 1ns / 1ps

package clt_pkg;

   localparam int CHAR_W      = 8;
   localparam int POS_W       = 5;
   localparam int ARG_INDEX_W = 2;
   localparam int ARG_COUNT_W = 3;

   localparam int MAX_ARGS_N = 4;
   localparam int LINE_MAX_N = 32;

   localparam logic [ARG_COUNT_W-1:0] MAX_ARGS  = ARG_COUNT_W'(MAX_ARGS_N);
   // Last buffer slot is kept back for the line terminator.
   localparam logic [POS_W-1:0]       LAST_SLOT = POS_W'(LINE_MAX_N - 1);

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;

   typedef struct packed {
      logic [CHAR_W-1:0]      out_byte;
      logic [POS_W-1:0]       out_pos;
      logic                   arg_start;
      logic [ARG_INDEX_W-1:0] arg_index;
      logic                   line_done;
      logic [ARG_COUNT_W-1:0] arg_count;
      logic                   overflow;
   } clt_result_type;

   // Space, tab, LF, VT, FF and CR.
   function automatic logic is_skip_space(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_separator(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB);
   endfunction

endpackage

// File: src/clt_core.sv
// Tokenizer state registers and the per-character next-state and result logic.
`timescale 1ns / 1ps

module clt_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [clt_pkg::CHAR_W-1:0]    ch,
   output logic                          result_valid,
   output clt_pkg::clt_result_type       result
);
   import clt_pkg::*;

   logic                   need_record_ff, need_record_in;
   logic                   skipping_ff, skipping_in;
   logic                   in_quotes_ff, in_quotes_in;
   logic [POS_W-1:0]       write_pos_ff, write_pos_in;
   logic [ARG_COUNT_W-1:0] args_seen_ff, args_seen_in;
   logic                   overflowed_ff, overflowed_in;
   logic                   start_pending_ff, start_pending_in;
   logic [ARG_INDEX_W-1:0] pending_index_ff, pending_index_in;

   always_comb begin
      logic                do_write;
      logic [CHAR_W-1:0]   wr_byte;
      logic                active;

      need_record_in   = need_record_ff;
      skipping_in      = skipping_ff;
      in_quotes_in     = in_quotes_ff;
      write_pos_in     = write_pos_ff;
      args_seen_in     = args_seen_ff;
      overflowed_in    = overflowed_ff;
      start_pending_in = start_pending_ff;
      pending_index_in = pending_index_ff;
      do_write         = 1'b0;
      wr_byte          = CH_NUL;
      active           = 1'b1;
      result_valid     = 1'b0;
      result           = '0;

      if (ch == CH_NUL) begin
         // Terminator: report and drop back to the reset state.
         result_valid     = accept;
         result.out_byte  = CH_NUL;
         result.out_pos   = write_pos_ff;
         result.arg_start = start_pending_ff;
         result.arg_index = start_pending_ff ? pending_index_ff : '0;
         result.line_done = 1'b1;
         result.arg_count = args_seen_ff;
         result.overflow  = overflowed_ff;
         need_record_in   = 1'b1;
         skipping_in      = 1'b0;
         in_quotes_in     = 1'b0;
         write_pos_in     = '0;
         args_seen_in     = '0;
         overflowed_in    = 1'b0;
         start_pending_in = 1'b0;
         pending_index_in = '0;
      end else begin
         if (need_record_ff) begin
            if (args_seen_ff < MAX_ARGS) begin
               start_pending_in = 1'b1;
               pending_index_in = args_seen_ff[ARG_INDEX_W-1:0];
               args_seen_in     = args_seen_ff + ARG_COUNT_W'(1);
            end
            need_record_in = 1'b0;
            skipping_in    = 1'b1;
         end

         if (skipping_in) begin
            if (is_skip_space(ch)) begin
               active = 1'b0;
            end else begin
               skipping_in = 1'b0;
            end
         end

         if (active) begin
            if (in_quotes_ff) begin
               if (ch == CH_QUOTE) begin
                  in_quotes_in = 1'b0;
               end else begin
                  do_write = 1'b1;
                  wr_byte  = ch;
               end
            end else if (is_separator(ch)) begin
               need_record_in = 1'b1;
               do_write       = 1'b1;
               wr_byte        = CH_NUL;
            end else if (ch == CH_QUOTE) begin
               in_quotes_in = 1'b1;
            end else begin
               do_write = 1'b1;
               wr_byte  = ch;
            end
         end

         if (do_write) begin
            if (write_pos_ff >= LAST_SLOT) begin
               overflowed_in = 1'b1;
            end else begin
               result_valid     = accept;
               result.out_byte  = wr_byte;
               result.out_pos   = write_pos_ff;
               result.arg_start = start_pending_in;
               result.arg_index = start_pending_in ? pending_index_in : '0;
               result.overflow  = overflowed_ff;
               start_pending_in = 1'b0;
               pending_index_in = '0;
               write_pos_in     = write_pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         need_record_ff   <= 1'b1;
         skipping_ff      <= 1'b0;
         in_quotes_ff     <= 1'b0;
         write_pos_ff     <= '0;
         args_seen_ff     <= '0;
         overflowed_ff    <= 1'b0;
         start_pending_ff <= 1'b0;
         pending_index_ff <= '0;
      end else if (accept) begin
         need_record_ff   <= need_record_in;
         skipping_ff      <= skipping_in;
         in_quotes_ff     <= in_quotes_in;
         write_pos_ff     <= write_pos_in;
         args_seen_ff     <= args_seen_in;
         overflowed_ff    <= overflowed_in;
         start_pending_ff <= start_pending_in;
         pending_index_ff <= pending_index_in;
      end
   end

endmodule

// File: src/clt_rsp_fifo.sv
// Two-entry registered result queue that decouples the result side from the input side.
`timescale 1ns / 1ps

module clt_rsp_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  clt_pkg::clt_result_type  push_data,
   input  logic                     pop,
   output logic                     head_valid,
   output logic                     full,
   output clt_pkg::clt_result_type  head
);
   import clt_pkg::*;

   logic [1:0]     count_ff, count_in;
   clt_result_type head_ff, head_in;
   clt_result_type tail_ff, tail_in;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case (count_ff)
         2'd0: begin
            if (push) begin
               head_in  = push_data;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = push_data;
            end else if (pop) begin
               count_in = 2'd0;
            end else if (push) begin
               tail_in  = push_data;
               count_in = 2'd2;
            end
         end
         default: begin
            // Full: no push can arrive, drain into the head.
            if (pop) begin
               head_in  = tail_ff;
               count_in = 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign head_valid = (count_ff != 2'd0);
   assign full       = (count_ff == 2'd2);
   assign head       = head_ff;

endmodule

// File: src/command_line_tokenizer.sv
// Top level of the command line tokenizer: stream ports, tokenizer core and result queue.
`timescale 1ns / 1ps

//  channel | direction | transfer carries
//  --------+-----------+--------------------------------------------------------
//  req_    | in        | one line character, 0 ends the line
//  rsp_    | out       | compacted byte with position, argument mark, line end
//
//  One character is taken per cycle while the result queue has a free entry;
//  the tokenizer state is a handful of flags and counters updated by short logic,
//  and a result lands in the queue the same edge.
//  Reset is synchronous and active high; it returns the tokenizer to the start
//  of a line and empties the result queue.
//  The two-entry result queue keeps req_tready high while one result waits;
//  req_tready drops only when both entries are held.

module command_line_tokenizer (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [12:8] out_pos, [14:13] arg_index,
                                    // [17:15] arg_count, [23:18] zero
   output logic        rsp_tlast,   // line_done
   output logic [1:0]  rsp_tuser    // [0] arg_start, [1] overflow
);
   import clt_pkg::*;

   logic           accept;
   logic           result_valid;
   clt_result_type result;
   logic           queue_full;
   clt_result_type head;

   // Take a character whenever the queue has a free entry.
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   clt_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .ch           (req_tdata),
      .result_valid (result_valid),
      .result       (result)
   );

   // Hold results until the downstream side takes them.
   clt_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (result_valid),
      .push_data  (result),
      .pop        (rsp_tvalid && rsp_tready),
      .head_valid (rsp_tvalid),
      .full       (queue_full),
      .head       (head)
   );

   assign rsp_tdata = {6'd0, head.arg_count, head.arg_index, head.out_pos, head.out_byte};
   assign rsp_tlast = head.line_done;
   assign rsp_tuser = {head.overflow, head.arg_start};

endmodule

// File: src/command_line_tokenizer_checker.sv
// Port-level checks for the command line tokenizer, bound to the top level.
`timescale 1ns / 1ps

module command_line_tokenizer_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // The line end transfer always carries a zero byte.
   a_done_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[7:0] == 8'd0)
      else $error("line end with non-zero byte");

   // The argument count shows only on the line end.
   a_count_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[17:15] == 3'd0)
      else $error("argument count outside line end");

   // No index without a start mark.
   a_index_needs_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[14:13] == 2'd0)
      else $error("argument index without start mark");

   // Reset empties the result queue, so nothing is shown and the input is free.
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("result shown or input blocked straight after reset");

endmodule

bind command_line_tokenizer command_line_tokenizer_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/tb_top.sv
// Self-checking testbench for the command line tokenizer: directed table, random lines, predictor.
`timescale 1ns / 1ps

module tb_top;
   import clt_pkg::*;

   // Bytes that are only skipped at a line start or right after a separator; elsewhere they are plain data.
   localparam logic [CHAR_W-1:0] CH_VT = 8'h0B;
   localparam logic [CHAR_W-1:0] CH_FF = 8'h0C;

   localparam int RANDOM_ITEMS   = 850;
   localparam int DRAIN_CYCLES   = 10;
   localparam int HOLD_OFF       = 100;
   localparam int WATCHDOG_LIMIT = 2000;

   // One stimulus row: the character and, where it can be read off directly, its result.
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              typed;
      clt_result_type    want;
   } char_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;

   command_line_tokenizer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Tokenizer state as the testbench sees it.
   logic                   tok_need_record;
   logic                   tok_skipping;
   logic                   tok_in_quotes;
   logic [POS_W-1:0]       tok_wr_pos;
   logic [ARG_COUNT_W-1:0] tok_arg_total;
   logic                   tok_overflowed;
   logic                   tok_mark_pending;
   logic [ARG_INDEX_W-1:0] tok_mark_index;

   clt_result_type line_results_q[$];
   logic [CHAR_W-1:0] random_chars_q[$];
   char_row_type offered_row;
   char_row_type dir_rows [0:24];

   int mismatch_count = 0;
   int chars_taken    = 0;
   int results_seen   = 0;
   int lines_seen     = 0;
   int overflow_lines = 0;
   int full_lines     = 0;
   int quiet_cycles   = 0;

   task automatic clear_line_state();
      tok_need_record  = 1'b1;
      tok_skipping     = 1'b0;
      tok_in_quotes    = 1'b0;
      tok_wr_pos       = '0;
      tok_arg_total    = '0;
      tok_overflowed   = 1'b0;
      tok_mark_pending = 1'b0;
      tok_mark_index   = '0;
   endtask

   // Blanks swallowed while skipping: space and the range tab..CR.
   function automatic logic is_blank_char(input logic [CHAR_W-1:0] c);
      case (c)
         CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Characters that end an argument outside quotes.
   function automatic logic is_word_break(input logic [CHAR_W-1:0] c);
      case (c)
         CH_SPACE, CH_TAB, CH_LF, CH_CR: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic clt_result_type form_result(input logic [CHAR_W-1:0] b,
                                                  input logic done);
      clt_result_type r;
      r.out_byte  = b;
      r.out_pos   = tok_wr_pos;
      r.arg_start = tok_mark_pending;
      r.arg_index = tok_mark_pending ? tok_mark_index : '0;
      r.line_done = done;
      r.arg_count = done ? tok_arg_total : '0;
      r.overflow  = tok_overflowed;
      return r;
   endfunction

   // Advance the tokenizer by one character; flag whether a result comes out.
   task automatic tokenize_char(input logic [CHAR_W-1:0] c, output logic emitted,
                                output clt_result_type r);
      logic              do_write;
      logic [CHAR_W-1:0] wr_byte;
      emitted  = 1'b0;
      r        = '0;
      do_write = 1'b0;
      wr_byte  = c;
      if (c == CH_NUL) begin
         // Terminator carries the count and any mark still pending, then start afresh.
         r       = form_result(CH_NUL, 1'b1);
         emitted = 1'b1;
         clear_line_state();
      end else begin
         if (tok_need_record) begin
            if (tok_arg_total < MAX_ARGS) begin
               tok_mark_pending = 1'b1;
               tok_mark_index   = tok_arg_total[ARG_INDEX_W-1:0];
               tok_arg_total    = tok_arg_total + 1'b1;
            end
            tok_need_record = 1'b0;
            tok_skipping    = 1'b1;
         end
         if (!(tok_skipping && is_blank_char(c))) begin
            tok_skipping = 1'b0;
            if (tok_in_quotes) begin
               if (c == CH_QUOTE) tok_in_quotes = 1'b0;
               else do_write = 1'b1;
            end else if (is_word_break(c)) begin
               tok_need_record = 1'b1;
               do_write        = 1'b1;
               wr_byte         = CH_NUL;
            end else if (c == CH_QUOTE) begin
               tok_in_quotes = 1'b1;
            end else begin
               do_write = 1'b1;
            end
         end
         if (do_write) begin
            // Keep the last slot for the terminator; drop the write but hold the mark.
            if (tok_wr_pos >= LAST_SLOT) begin
               tok_overflowed = 1'b1;
            end else begin
               r                = form_result(wr_byte, 1'b0);
               emitted          = 1'b1;
               tok_mark_pending = 1'b0;
               tok_mark_index   = '0;
               tok_wr_pos       = tok_wr_pos + 1'b1;
            end
         end
      end
   endtask

   task automatic compare_result(input clt_result_type want, input clt_result_type got);
      if (got.out_byte !== want.out_byte) begin
         $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
         mismatch_count++;
      end
      if (got.out_pos !== want.out_pos) begin
         $error("out_pos: expected %0d, got %0d", want.out_pos, got.out_pos);
         mismatch_count++;
      end
      if (got.arg_start !== want.arg_start) begin
         $error("arg_start: expected %0b, got %0b", want.arg_start, got.arg_start);
         mismatch_count++;
      end
      if (got.arg_index !== want.arg_index) begin
         $error("arg_index: expected %0d, got %0d", want.arg_index, got.arg_index);
         mismatch_count++;
      end
      if (got.line_done !== want.line_done) begin
         $error("line_done: expected %0b, got %0b", want.line_done, got.line_done);
         mismatch_count++;
      end
      if (got.arg_count !== want.arg_count) begin
         $error("arg_count: expected %0d, got %0d", want.arg_count, got.arg_count);
         mismatch_count++;
      end
      if (got.overflow !== want.overflow) begin
         $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
         mismatch_count++;
      end
   endtask

   // Sample both channels at the rising edge: check results first, then predict
   // from the character accepted at the same edge, then look after the watchdog.
   always @(posedge clock) begin : monitor
      clt_result_type got;
      clt_result_type predicted;
      logic           emitted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.out_byte  = rsp_tdata[7:0];
            got.out_pos   = rsp_tdata[12:8];
            got.arg_index = rsp_tdata[14:13];
            got.arg_count = rsp_tdata[17:15];
            got.line_done = rsp_tlast;
            got.arg_start = rsp_tuser[0];
            got.overflow  = rsp_tuser[1];
            if (line_results_q.size() == 0) begin
               $error("unexpected result: byte %0h at position %0d", got.out_byte, got.out_pos);
               mismatch_count++;
            end else begin
               compare_result(line_results_q.pop_front(), got);
            end
            results_seen++;
            if (got.line_done) begin
               lines_seen++;
               if (got.overflow) overflow_lines++;
               if (got.arg_count == MAX_ARGS) full_lines++;
            end
         end
         if (req_tvalid && req_tready) begin
            tokenize_char(req_tdata, emitted, predicted);
            // Rows with a typed result stand in for the predictor's word.
            if (emitted) line_results_q.push_back(offered_row.typed ? offered_row.want : predicted);
            chars_taken++;
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Short gaps mostly, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      else if (roll < 85) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 10);
      else return $urandom_range(20, 40);
   endfunction

   // Receiver: random stalls, calm stretches, and one long hold-off mid-run so
   // that the result queue fills and the input stalls.
   initial begin : receiver
      int run;
      int stall;
      logic held_off;
      held_off   = 1'b0;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (!held_off && chars_taken > 300) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
         end
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
         rsp_tready <= 1'b1;
         repeat (run) @(negedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   int calm_left = 0;

   // Offer one row at the falling edge and hold it until the handshake.
   task automatic send_row(input char_row_type row);
      int gap;
      gap = (calm_left > 0) ? 0 : pick_gap();
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(20, 60);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid  <= 1'b1;
      req_tdata   <= row.ch;
      offered_row <= row;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [CHAR_W-1:0] break_char();
      case ($urandom_range(0, 5))
         0, 1:    return CH_SPACE;
         2:       return CH_TAB;
         3:       return CH_CR;
         4:       return CH_LF;
         default: return $urandom_range(0, 1) ? CH_VT : CH_FF;
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] word_char();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) return CH_QUOTE;
      else if (roll < 18) return CH_SPACE;
      else if (roll < 82) return 8'($urandom_range(8'h21, 8'h7E));
      else return 8'($urandom_range(1, 255));
   endfunction

   // Mostly well-formed lines of words with quotes and blanks; some pure noise.
   task automatic add_random_line();
      int words;
      int len;
      int seps;
      if ($urandom_range(0, 9) == 0) begin
         len = $urandom_range(0, 40);
         repeat (len) random_chars_q.push_back(8'($urandom_range(1, 255)));
      end else begin
         words = $urandom_range(0, 7);
         if ($urandom_range(0, 3) == 0) random_chars_q.push_back(break_char());
         for (int w = 0; w < words; w++) begin
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
            repeat (len) random_chars_q.push_back(word_char());
            seps = (w == words - 1) ? $urandom_range(0, 2) : $urandom_range(1, 3);
            repeat (seps) random_chars_q.push_back(break_char());
         end
      end
      random_chars_q.push_back(CH_NUL);
   endtask

   initial begin : stimulus
      char_row_type plain;
      req_tvalid  = 1'b0;
      req_tdata   = CH_NUL;
      offered_row = '0;
      reset       = 1'b1;
      clear_line_state();

      // Fields: out_byte, out_pos, arg_start, arg_index, line_done, arg_count, overflow.
      dir_rows = '{
         // empty line straight after reset
         '{CH_NUL,   1'b1, '{8'h00, 5'd0, 1'b0, 2'd0, 1'b1, 3'd0, 1'b0}},
         // first argument marked on its first byte
         '{8'h61,    1'b1, '{8'h61, 5'd0, 1'b1, 2'd0, 1'b0, 3'd0, 1'b0}},
         '{CH_SPACE, 1'b0, '0},
         // quoted argument keeping a blank and the top byte value
         '{CH_QUOTE, 1'b0, '0},
         '{CH_SPACE, 1'b0, '0},
         '{8'hFF,    1'b1, '{8'hFF, 5'd3, 1'b0, 2'd0, 1'b0, 3'd0, 1'b0}},
         '{CH_QUOTE, 1'b0, '0},
         // VT is plain data outside the skip phase
         '{CH_VT,    1'b0, '0},
         '{CH_TAB,   1'b0, '0},
         // FF, CR and LF swallowed while skipping
         '{CH_FF,    1'b0, '0},
         '{CH_CR,    1'b0, '0},
         '{CH_LF,    1'b0, '0},
         '{8'h01,    1'b0, '0},
         '{CH_LF,    1'b0, '0},
         // trailing blanks record an empty fourth argument, marked on the terminator
         '{CH_SPACE, 1'b0, '0},
         '{CH_NUL,   1'b1, '{8'h00, 5'd8, 1'b1, 2'd3, 1'b1, 3'd4, 1'b0}},
         // separator right before the end records nothing
         '{8'h78,    1'b0, '0},
         '{CH_SPACE, 1'b0, '0},
         '{CH_NUL,   1'b0, '0},
         // argument made only of quotes
         '{CH_QUOTE, 1'b0, '0},
         '{CH_QUOTE, 1'b0, '0},
         '{CH_NUL,   1'b1, '{8'h00, 5'd0, 1'b1, 2'd0, 1'b1, 3'd1, 1'b0}},
         // quote left open at the end of the line
         '{CH_QUOTE, 1'b0, '0},
         '{8'h71,    1'b0, '0},
         '{CH_NUL,   1'b0, '0}
      };

      while (random_chars_q.size() < RANDOM_ITEMS) add_random_line();

      // Hold reset, then release it at a falling edge.
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_row(dir_rows[i]);
      plain = '0;
      while (random_chars_q.size() > 0) begin
         plain.ch = random_chars_q.pop_front();
         send_row(plain);
      end
      req_tvalid <= 1'b0;

      // Drain outstanding results, then allow the pipeline to settle.
      while (line_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d characters in %0d lines, %0d results checked",
               chars_taken, lines_seen, results_seen);
      $display("%0d lines overflowed the buffer, %0d reached the argument limit",
               overflow_lines, full_lines);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
